// ----- rtl/integer_array_sorter_top_defines.svh -----
// Assertion macros for the sorter top level.
`ifndef INTEGER_ARRAY_SORTER_TOP_DEFINES_SVH
`define INTEGER_ARRAY_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during rst.
`define IAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define IAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ias_pkg.sv -----
// Types and constants for the integer array sorter.
`timescale 1ns / 1ps

package ias_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               truncated;
  } out_res_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic               lt;
  } cell_link_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/ias_cell.sv -----
// One insertion cell of the sorting chain.
`timescale 1ns / 1ps

module ias_cell (
  input  logic                clk,
  input  logic                rst,
  input  ias_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  new_value,
  input  ias_pkg::cell_link_t left,
  input  ias_pkg::cell_link_t right,
  output ias_pkg::cell_link_t self
);

  logic signed [31:0] value;
  logic               valid;
  logic signed [31:0] value_next;
  logic               valid_next;
  logic               lt;

  // new value goes ahead of this cell (empty cells count as +inf)
  assign lt = !valid || (new_value < value);

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.shift) begin
      value_next = right.value;
      valid_next = right.valid;
    end else if (ctrl.insert && lt) begin
      if (left.lt) begin
        value_next = left.value;
        valid_next = left.valid;
      end else begin
        value_next = new_value;
        valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  assign self.value = value;
  assign self.valid = valid;
  assign self.lt    = lt;

endmodule

// ----- rtl/integer_array_sorter_top.sv -----
// Top level of the integer array sorter: insertion cell chain and drain control.
//
// channel  | ports                       | transfer
// request  | start, busy, req            | start && !busy
// result   | strobe, result              | strobe (no stall)
//
// Loading: one request per cycle; each is inserted into the cell chain in place.
// After a request marked last, the chain drains one value per cycle until all
// elements held are out, busy high throughout; then busy drops.
// Requests beyond CAPACITY elements are dropped and flag the whole set truncated.
// Reset clears all cell valid bits, the count and the overflow flag.
`timescale 1ns / 1ps
`include "integer_array_sorter_top_defines.svh"

module integer_array_sorter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ias_pkg::in_req_t   req,
  output logic               strobe,
  output ias_pkg::out_res_t  result
);

  localparam int N = ias_pkg::CAPACITY;

  ias_pkg::state_t           state;
  ias_pkg::state_t           state_next;
  logic [ias_pkg::CNT_W-1:0] count;
  logic [ias_pkg::CNT_W-1:0] count_next;
  logic                      ovf;
  logic                      ovf_next;

  logic                      accept;
  logic                      full;
  ias_pkg::cell_ctrl_t       ctrl;
  ias_pkg::cell_link_t       links [N];
  ias_pkg::cell_link_t       edge_link;

  assign accept = start && !busy;
  assign full   = (count == ias_pkg::CNT_W'(ias_pkg::CAPACITY));

  assign edge_link.value = '0;
  assign edge_link.valid = 1'b0;
  assign edge_link.lt    = 1'b0;

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state == ias_pkg::ST_DRAIN);

  for (genvar i = 0; i < N; i++) begin : g_cell
    ias_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_value (req.value),
      .left      ((i == 0) ? edge_link : links[(i == 0) ? 0 : i - 1]),
      .right     ((i == N - 1) ? edge_link : links[(i == N - 1) ? i : i + 1]),
      .self      (links[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    case (state)
      ias_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            count_next = count + ias_pkg::CNT_W'(1);
          end
          if (req.last) begin
            state_next = ias_pkg::ST_DRAIN;
          end
        end
      end
      ias_pkg::ST_DRAIN: begin
        count_next = count - ias_pkg::CNT_W'(1);
        if (count == ias_pkg::CNT_W'(1)) begin
          state_next = ias_pkg::ST_LOAD;
          ovf_next   = 1'b0;
        end
      end
      default: begin
        state_next = ias_pkg::ST_LOAD;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy                = 1'b0;
    strobe              = 1'b0;
    result.sorted_value = links[0].value;
    result.final_res    = (count == ias_pkg::CNT_W'(1));
    result.truncated    = ovf;
    case (state)
      ias_pkg::ST_LOAD: begin
        busy   = 1'b0;
        strobe = 1'b0;
      end
      ias_pkg::ST_DRAIN: begin
        busy   = 1'b1;
        strobe = 1'b1;
      end
      default: begin
        busy   = 1'b0;
        strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ias_pkg::ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  `IAS_ASSERT_NEXT(a_last_starts_drain, accept && req.last, strobe, "last request did not start drain")
  `IAS_ASSERT_NEXT(a_final_ends_drain, strobe && result.final_res, !busy, "busy after final result")
  `IAS_ASSERT_NEXT(a_drain_no_gap, strobe && !result.final_res, strobe, "gap in result burst")
  `IAS_ASSERT_NEXT(a_ascending, strobe && !result.final_res, $past(result.sorted_value) <= result.sorted_value, "results out of order")
  `IAS_ASSERT_NOW(a_drain_has_data, strobe, links[0].valid && (count != '0), "drain from empty chain")

endmodule
